[rtl/core/gsoc_pkg.sv]
// Shared constants and codes for the grid segment overlap counter.
// No dependencies; every other file in rtl/core but gsoc_ram refers to this package.
`timescale 1ns / 1ps

package gsoc_pkg;

    // Payload field widths.
    localparam int COORD_W = 10;
    localparam int COUNT_W = 21;

    // Grid size default (cells per side).
    localparam int GRID_SIZE_DEF = 1024;

    // Coverage cell: saturating count plus an epoch tag for fast clears.
    localparam int CELL_W  = 2;
    localparam int EPOCH_W = 4;
    localparam logic [CELL_W-1:0] CELL_SAT = 2'd2;

    localparam logic [COUNT_W-1:0] TALLY_MAX = {COUNT_W{1'b1}};

    // Command codes.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_INCLUDE_DIAG = 1'b0;
    localparam logic DIAG_RESET = 1'b1;

endpackage

[rtl/core/gsoc_if.sv]
// Handshake interfaces for segment input beats and result beats.
// Depends on gsoc_pkg for the payload widths.
`timescale 1ns / 1ps

interface gsoc_seg_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [gsoc_pkg::COORD_W-1:0] start_x;
    logic [gsoc_pkg::COORD_W-1:0] start_y;
    logic [gsoc_pkg::COORD_W-1:0] end_x;
    logic [gsoc_pkg::COORD_W-1:0] end_y;

    modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface gsoc_res_if;
    logic                        valid;
    logic                        ready;
    logic [gsoc_pkg::COUNT_W-1:0] overlap_count;
    logic                        segment_ignored;

    modport source (output valid, overlap_count, segment_ignored, input ready);
    modport sink   (input valid, overlap_count, segment_ignored, output ready);
endinterface

[rtl/core/grid_segment_overlap_counter_unit.sv]
// Grid segment overlap counter: top level joining config, walker and coverage RAM.
// Depends on gsoc_pkg, gsoc_if.sv, gsoc_cfg, gsoc_walker and gsoc_ram.
//
// Usage:
//   Input beats on seg carry a command and two end points. An add command
//   draws a horizontal, vertical or (if enabled) 45 degree segment into a
//   GRID_SIZE x GRID_SIZE coverage RAM; a clear command empties it. Every
//   input beat yields exactly one result beat on res with the running count
//   of cells covered at least twice and a flag for segments not drawn.
//   An add is decoded, then walked with one RAM read-modify-write per cell
//   (read and write-back overlap) and drained before its result is loaded.
//   Ignored segments and most clears go from decode to the result. Cells
//   carry a 4-bit epoch tag, so a clear just bumps the epoch; every
//   sixteenth clear runs a sweep over all GRID_SIZE*GRID_SIZE RAM cells instead.
//   After reset the same sweep runs with seg.ready low; configuration
//   writes are taken throughout.
//   A finished result sits in an output register; the block takes the next
//   input beat while it waits, and holds a second result until res.ready.
//   The APB port holds the diagonal enable at address 0 (bit 0, reset 1).
`timescale 1ns / 1ps

module grid_segment_overlap_counter_unit #(
    parameter int GRID_SIZE = gsoc_pkg::GRID_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    gsoc_seg_if.sink                     seg,
    gsoc_res_if.source                   res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsoc_pkg::PADDR_W-1:0] paddr,
    input  logic [gsoc_pkg::PDATA_W-1:0] pwdata,
    output logic [gsoc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW = $clog2(DEPTH);
    localparam int MW = gsoc_pkg::CELL_W + gsoc_pkg::EPOCH_W;

    logic          include_diagonals;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [MW-1:0] mem_rdata, mem_wdata;

    gsoc_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .include_diagonals (include_diagonals)
    );

    gsoc_walker #(
        .GRID_SIZE (GRID_SIZE)
    ) u_walker (
        .clk               (clk),
        .rst_n             (rst_n),
        .include_diagonals (include_diagonals),
        .seg               (seg),
        .res               (res),
        .mem_re            (mem_re),
        .mem_raddr         (mem_raddr),
        .mem_rdata         (mem_rdata),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata)
    );

    gsoc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_coverage_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[rtl/core/gsoc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gsoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gsoc_cfg.sv]
// APB-style configuration register file (diagonal enable).
// Depends on gsoc_pkg.
`timescale 1ns / 1ps

module gsoc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsoc_pkg::PADDR_W-1:0] paddr,
    input  logic [gsoc_pkg::PDATA_W-1:0] pwdata,
    output logic [gsoc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic                         include_diagonals
);

    logic diag_reg;
    logic diag_next;
    logic sel_diag;

    // Registers sit on 4-byte boundaries; bit 2 picks the register.
    assign sel_diag = (paddr[2] == gsoc_pkg::REG_INCLUDE_DIAG);

    always_comb
    begin
        diag_next = diag_reg;
        if (psel && penable && pwrite && sel_diag)
        begin
            diag_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= gsoc_pkg::DIAG_RESET;
        end
        else
        begin
            diag_reg <= diag_next;
        end
    end

    assign prdata = sel_diag ? {{(gsoc_pkg::PDATA_W-1){1'b0}}, diag_reg} : '0;
    assign pready = 1'b1;
    assign include_diagonals = diag_reg;

endmodule

[rtl/core/gsoc_walker.sv]
// Segment decoder, cell walker and read-modify-write control for the coverage RAM.
// Depends on gsoc_pkg and the handshake interfaces in gsoc_if.sv.
`timescale 1ns / 1ps

module gsoc_walker #(
    parameter int GRID_SIZE = gsoc_pkg::GRID_SIZE_DEF,
    localparam int DEPTH = GRID_SIZE * GRID_SIZE,
    localparam int AW = $clog2(DEPTH),
    localparam int MW = gsoc_pkg::CELL_W + gsoc_pkg::EPOCH_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          include_diagonals,
    gsoc_seg_if.sink      seg,
    gsoc_res_if.source    res,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [MW-1:0] mem_rdata,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [MW-1:0] mem_wdata
);

    localparam int CW = gsoc_pkg::COORD_W;
    localparam int NW = gsoc_pkg::COUNT_W;
    localparam int EW = gsoc_pkg::EPOCH_W;
    localparam int SW = gsoc_pkg::CELL_W;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DECODE = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic [CW-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic [CW-1:0]   bx_reg, bx_next, by_reg, by_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   step_reg, step_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            wr_pend_reg, wr_pend_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [EW-1:0]   epoch_reg, epoch_next;
    logic [NW-1:0]   tally_reg, tally_next;
    logic            ignored_reg, ignored_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            clr_reply_reg, clr_reply_next;
    logic            out_valid_reg, out_valid_next;
    logic [NW-1:0]   out_count_reg, out_count_next;
    logic            out_ignored_reg, out_ignored_next;

    // Segment decode.
    logic          xup, yup;
    logic [CW-1:0] dx, dy, span;
    logic          on_grid, draw;
    logic [AW-1:0] start_addr, xstep, ystep;

    // Write-back stage.
    logic [EW-1:0] rd_tag;
    logic [SW-1:0] rd_cnt, cur_cnt, new_cnt;
    logic          reach_two;
    logic          load_out;

    always_comb
    begin
        xup = (bx_reg >= ax_reg);
        yup = (by_reg >= ay_reg);
        dx = xup ? (bx_reg - ax_reg) : (ax_reg - bx_reg);
        dy = yup ? (by_reg - ay_reg) : (ay_reg - by_reg);
        span = (dx > dy) ? dx : dy;
        on_grid = (32'(ax_reg) < 32'(GRID_SIZE)) && (32'(ay_reg) < 32'(GRID_SIZE)) &&
                  (32'(bx_reg) < 32'(GRID_SIZE)) && (32'(by_reg) < 32'(GRID_SIZE));
        draw = on_grid && ((dx == '0) || (dy == '0) || ((dx == dy) && include_diagonals));
        start_addr = AW'(ay_reg) * AW'(GRID_SIZE) + AW'(ax_reg);
        // Steps are kept modulo the address range, so a move left or up is an add.
        if (dx == '0)
        begin
            xstep = '0;
        end
        else
        begin
            xstep = xup ? AW'(1) : ('0 - AW'(1));
        end
        if (dy == '0)
        begin
            ystep = '0;
        end
        else
        begin
            ystep = yup ? AW'(GRID_SIZE) : ('0 - AW'(GRID_SIZE));
        end
    end

    // A cell whose tag is from an older epoch counts as empty.
    always_comb
    begin
        rd_tag = mem_rdata[MW-1:SW];
        rd_cnt = mem_rdata[SW-1:0];
        cur_cnt = (rd_tag == epoch_reg) ? rd_cnt : '0;
        new_cnt = (cur_cnt == gsoc_pkg::CELL_SAT) ? cur_cnt : cur_cnt + SW'(1);
        reach_two = (cur_cnt == gsoc_pkg::CELL_SAT - SW'(1));
    end

    assign mem_re    = (state_reg == ST_WALK);
    assign mem_raddr = addr_reg;
    assign mem_we    = (state_reg == ST_CLEAR) || wr_pend_reg;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : wr_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : {epoch_reg, new_cnt};

    assign load_out = (state_reg == ST_RESULT) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        addr_next = addr_reg;
        step_next = step_reg;
        rem_next = rem_reg;
        wr_pend_next = (state_reg == ST_WALK);
        wr_addr_next = addr_reg;
        epoch_next = epoch_reg;
        tally_next = tally_reg;
        ignored_next = ignored_reg;
        clr_addr_next = clr_addr_reg;
        clr_reply_next = clr_reply_reg;

        if (wr_pend_reg && reach_two && (tally_reg != gsoc_pkg::TALLY_MAX))
        begin
            tally_next = tally_reg + NW'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    epoch_next = '0;
                    ignored_next = 1'b0;
                    state_next = clr_reply_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (seg.valid)
                begin
                    cmd_next = seg.command;
                    ax_next = seg.start_x;
                    ay_next = seg.start_y;
                    bx_next = seg.end_x;
                    by_next = seg.end_y;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (cmd_reg == gsoc_pkg::CMD_CLEAR)
                begin
                    tally_next = '0;
                    ignored_next = 1'b0;
                    // Epoch wrap would alias old cells, so sweep the RAM instead.
                    if (epoch_reg == {EW{1'b1}})
                    begin
                        clr_addr_next = '0;
                        clr_reply_next = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EW'(1);
                        state_next = ST_RESULT;
                    end
                end
                else if (!draw)
                begin
                    ignored_next = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    ignored_next = 1'b0;
                    addr_next = start_addr;
                    step_next = xstep + ystep;
                    rem_next = span;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                addr_next = addr_reg + step_reg;
                rem_next = rem_reg - CW'(1);
                if (rem_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_ignored_next = out_ignored_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_count_next = tally_reg;
            out_ignored_next = ignored_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wr_pend_reg <= 1'b0;
            epoch_reg <= '0;
            tally_reg <= '0;
            clr_addr_reg <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wr_pend_reg <= wr_pend_next;
            epoch_reg <= epoch_next;
            tally_reg <= tally_next;
            clr_addr_reg <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        bx_reg <= bx_next;
        by_reg <= by_next;
        addr_reg <= addr_next;
        step_reg <= step_next;
        rem_reg <= rem_next;
        wr_addr_reg <= wr_addr_next;
        ignored_reg <= ignored_next;
        out_count_reg <= out_count_next;
        out_ignored_reg <= out_ignored_next;
    end

    assign seg.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.overlap_count = out_count_reg;
    assign res.segment_ignored = out_ignored_reg;

endmodule

[rtl/core/gsoc_checker.sv]
// Port-level checks for the grid segment overlap counter, bound to the top level.
// Depends on gsoc_pkg and grid_segment_overlap_counter_unit.
`timescale 1ns / 1ps

module gsoc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         seg_valid,
    input logic                         seg_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [gsoc_pkg::COUNT_W-1:0] overlap_count,
    input logic                         segment_ignored,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [gsoc_pkg::PADDR_W-1:0] paddr,
    input logic [gsoc_pkg::PDATA_W-1:0] pwdata,
    input logic [gsoc_pkg::PDATA_W-1:0] prdata
);

    logic                         in_beat, out_beat;
    logic [1:0]                   pending_reg, pending_next;
    logic [gsoc_pkg::COUNT_W-1:0] last_count_reg;
    logic                         seen_reg;

    assign in_beat  = seg_valid && seg_ready;
    assign out_beat = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_beat)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_beat)
        begin
            last_count_reg <= overlap_count;
        end
    end

    // A stalled result must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(overlap_count) &&
        $stable(segment_ignored))
    else $error("result changed while stalled");

    // Results only for accepted segments, and never more than two in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 2'd3) && (!res_valid || pending_reg != 2'd0))
    else $error("result count does not match accepted segments");

    // A segment that was not drawn leaves the tally unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && segment_ignored && seen_reg |-> overlap_count == last_count_reg)
    else $error("ignored segment changed the overlap count");

    // The diagonal enable reads back what was written.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == gsoc_pkg::REG_INCLUDE_DIAG) ##1
        (paddr[2] == gsoc_pkg::REG_INCLUDE_DIAG) |-> prdata[0] == $past(pwdata[0]))
    else $error("configuration readback mismatch");

endmodule

bind grid_segment_overlap_counter_unit gsoc_checker u_gsoc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .seg_valid       (seg.valid),
    .seg_ready       (seg.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .overlap_count   (res.overlap_count),
    .segment_ignored (res.segment_ignored),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);
